/* rtl/text_column_field_selector_macros.svh */
// Assertion macros shared by the selector modules.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef TEXT_COLUMN_FIELD_SELECTOR_MACROS_SVH
`define TEXT_COLUMN_FIELD_SELECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCFS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcfs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TCFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcfs assertion failed");

`endif

/* rtl/tcfs_pkg.sv */
package tcfs_pkg;

  // Sizes of the first-field buffer and the range list.
  localparam int FIRST_FIELD_DEPTH = 62;
  localparam int ADDR_W            = $clog2(FIRST_FIELD_DEPTH);
  localparam int CNT_W             = $clog2(FIRST_FIELD_DEPTH + 1);
  localparam int RANGE_COUNT       = 3;
  localparam int RANGE_PTR_W       = 2;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SELECT_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_A_START = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_A_END   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_B_START = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_B_END   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_C_START = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_C_END   = 3'd7;

  // Mode codes and character constants.
  localparam logic [1:0]  MODE_COLUMN     = 2'd0;
  localparam logic [7:0]  LINE_END        = 8'd10;
  localparam logic [7:0]  DELIMITER_RESET = 8'd9;
  localparam logic [15:0] OPEN_END        = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

  // Configuration registers.
  typedef struct packed {
    logic [1:0]  select_mode;
    logic [7:0]  delimiter_char;
    logic [15:0] range_a_start;
    logic [15:0] range_a_end;
    logic [15:0] range_b_start;
    logic [15:0] range_b_end;
    logic [15:0] range_c_start;
    logic [15:0] range_c_end;
  } cfg_t;

  // What one accepted byte produces: an optional drain of the buffered
  // first field followed by an optional single byte.
  typedef struct packed {
    logic             drain;
    logic [CNT_W-1:0] count;
    logic             tail;
    logic [7:0]       tail_byte;
    logic             flag;
  } plan_t;

  // Write request into the first-field store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  // Read request into the first-field store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_t;

  // Saturating increment, also the field number of a delimiter count.
  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v != COUNT_MAX) ? v + 16'd1 : COUNT_MAX;
  endfunction

  function automatic logic [15:0] start_of(input cfg_t c, input logic [RANGE_PTR_W-1:0] r);
    case (r)
      2'd0:    start_of = c.range_a_start;
      2'd1:    start_of = c.range_b_start;
      2'd2:    start_of = c.range_c_start;
      default: start_of = 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] end_of(input cfg_t c, input logic [RANGE_PTR_W-1:0] r);
    case (r)
      2'd0:    end_of = c.range_a_end;
      2'd1:    end_of = c.range_b_end;
      2'd2:    end_of = c.range_c_end;
      default: end_of = 16'd0;
    endcase
  endfunction

endpackage

/* rtl/tcfs_store.sv */
module tcfs_store (
  input  logic               clk,
  input  tcfs_pkg::wr_t      wr,
  input  tcfs_pkg::rd_t      rd,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [0:tcfs_pkg::FIRST_FIELD_DEPTH-1];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

/* rtl/tcfs_line.sv */
module tcfs_line (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [tcfs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tcfs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                cfg_ready,
  input  logic                                in_accept,
  input  logic [7:0]                          in_byte,
  output tcfs_pkg::plan_t                     plan,
  output tcfs_pkg::wr_t                       wr
);

  tcfs_pkg::cfg_t cfg;

  logic [15:0]                        position_count, position_count_next;
  logic                               inside_range, inside_range_next;
  logic [tcfs_pkg::RANGE_PTR_W-1:0]   range_pointer, range_pointer_next;
  logic                               delimiter_pending, delimiter_pending_next;
  logic                               delimiter_seen, delimiter_seen_next;
  logic [tcfs_pkg::CNT_W-1:0]         first_field_count, first_field_count_next;
  logic                               overflow_mark, overflow_mark_next;

  logic                               suppress;
  logic                               ptr_live;
  logic [15:0]                        field_no;

  assign cfg_ready = 1'b1;
  assign suppress  = cfg.select_mode[1];

  // Configuration registers, written whenever a request arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.select_mode    <= tcfs_pkg::MODE_COLUMN;
      cfg.delimiter_char <= tcfs_pkg::DELIMITER_RESET;
      cfg.range_a_start  <= '0;
      cfg.range_a_end    <= '0;
      cfg.range_b_start  <= '0;
      cfg.range_b_end    <= '0;
      cfg.range_c_start  <= '0;
      cfg.range_c_end    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tcfs_pkg::REG_SELECT_MODE:   cfg.select_mode    <= cfg_data[1:0];
        tcfs_pkg::REG_DELIMITER:     cfg.delimiter_char <= cfg_data[7:0];
        tcfs_pkg::REG_RANGE_A_START: cfg.range_a_start  <= cfg_data;
        tcfs_pkg::REG_RANGE_A_END:   cfg.range_a_end    <= cfg_data;
        tcfs_pkg::REG_RANGE_B_START: cfg.range_b_start  <= cfg_data;
        tcfs_pkg::REG_RANGE_B_END:   cfg.range_b_end    <= cfg_data;
        tcfs_pkg::REG_RANGE_C_START: cfg.range_c_start  <= cfg_data;
        tcfs_pkg::REG_RANGE_C_END:   cfg.range_c_end    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Decode one byte against the line state. The steps below follow the
  // order of opening, closing and re-opening a range within one byte.
  always_comb begin
    position_count_next    = position_count;
    inside_range_next      = inside_range;
    range_pointer_next     = range_pointer;
    delimiter_pending_next = delimiter_pending;
    delimiter_seen_next    = delimiter_seen;
    first_field_count_next = first_field_count;
    overflow_mark_next     = overflow_mark;
    plan                   = '0;
    wr                     = '0;
    wr.addr                = first_field_count[tcfs_pkg::ADDR_W-1:0];
    wr.data                = in_byte;
    ptr_live               = 1'b0;
    field_no               = '0;

    if (cfg.select_mode == tcfs_pkg::MODE_COLUMN) begin
      if (in_byte == tcfs_pkg::LINE_END) begin
        plan.tail      = 1'b1;
        plan.tail_byte = tcfs_pkg::LINE_END;
      end else begin
        position_count_next = tcfs_pkg::sat_inc(position_count);
        ptr_live = range_pointer < tcfs_pkg::RANGE_PTR_W'(tcfs_pkg::RANGE_COUNT);
        if (!inside_range_next && ptr_live &&
            position_count_next == tcfs_pkg::start_of(cfg, range_pointer_next)) begin
          inside_range_next = 1'b1;
        end
        if (inside_range_next) begin
          plan.tail      = 1'b1;
          plan.tail_byte = in_byte;
          if (ptr_live &&
              tcfs_pkg::end_of(cfg, range_pointer_next) != tcfs_pkg::OPEN_END &&
              position_count_next == tcfs_pkg::end_of(cfg, range_pointer_next)) begin
            inside_range_next  = 1'b0;
            range_pointer_next = range_pointer_next + 1'b1;
          end
        end
      end
    end else begin
      plan.flag = overflow_mark;
      if (in_byte == tcfs_pkg::LINE_END) begin
        // A line without a delimiter is passed whole or dropped.
        if (!delimiter_seen) begin
          if (!suppress) begin
            plan.drain     = 1'b1;
            plan.count     = first_field_count;
            plan.tail      = 1'b1;
            plan.tail_byte = tcfs_pkg::LINE_END;
          end
        end else begin
          plan.tail      = 1'b1;
          plan.tail_byte = tcfs_pkg::LINE_END;
        end
      end else if (in_byte == cfg.delimiter_char) begin
        field_no = tcfs_pkg::sat_inc(position_count);
        // First delimiter: decide on the buffered first field.
        if (!delimiter_seen) begin
          delimiter_seen_next = 1'b1;
          ptr_live = range_pointer_next < tcfs_pkg::RANGE_PTR_W'(tcfs_pkg::RANGE_COUNT);
          if (!inside_range_next && ptr_live &&
              field_no == tcfs_pkg::start_of(cfg, range_pointer_next)) begin
            inside_range_next = 1'b1;
          end
          if (inside_range_next) begin
            delimiter_pending_next = 1'b1;
            plan.drain             = 1'b1;
            plan.count             = first_field_count;
          end
        end
        // Close the field that ends here.
        ptr_live = range_pointer_next < tcfs_pkg::RANGE_PTR_W'(tcfs_pkg::RANGE_COUNT);
        if (inside_range_next && ptr_live &&
            tcfs_pkg::end_of(cfg, range_pointer_next) != tcfs_pkg::OPEN_END &&
            field_no == tcfs_pkg::end_of(cfg, range_pointer_next)) begin
          inside_range_next  = 1'b0;
          range_pointer_next = range_pointer_next + 1'b1;
        end
        position_count_next = tcfs_pkg::sat_inc(position_count);
        // Enter the next field; a joining delimiter goes out if one is owed.
        ptr_live = range_pointer_next < tcfs_pkg::RANGE_PTR_W'(tcfs_pkg::RANGE_COUNT);
        if (!inside_range_next && ptr_live &&
            tcfs_pkg::sat_inc(position_count_next) ==
            tcfs_pkg::start_of(cfg, range_pointer_next)) begin
          inside_range_next = 1'b1;
        end
        if (inside_range_next) begin
          if (delimiter_pending_next) begin
            plan.tail      = 1'b1;
            plan.tail_byte = cfg.delimiter_char;
          end
          delimiter_pending_next = 1'b1;
        end
      end else if (!delimiter_seen) begin
        // Buffer the first field; bytes that do not fit are dropped.
        if (first_field_count < tcfs_pkg::CNT_W'(tcfs_pkg::FIRST_FIELD_DEPTH)) begin
          wr.en                  = in_accept;
          first_field_count_next = first_field_count + 1'b1;
        end else begin
          overflow_mark_next = 1'b1;
        end
      end else if (inside_range) begin
        plan.tail      = 1'b1;
        plan.tail_byte = in_byte;
      end
    end

    // A newline ends the line in every mode.
    if (in_byte == tcfs_pkg::LINE_END) begin
      position_count_next    = '0;
      inside_range_next      = 1'b0;
      range_pointer_next     = '0;
      delimiter_pending_next = 1'b0;
      delimiter_seen_next    = 1'b0;
      first_field_count_next = '0;
      overflow_mark_next     = 1'b0;
    end
  end

  // Line state advances on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count    <= '0;
      inside_range      <= 1'b0;
      range_pointer     <= '0;
      delimiter_pending <= 1'b0;
      delimiter_seen    <= 1'b0;
      first_field_count <= '0;
      overflow_mark     <= 1'b0;
    end else if (in_accept) begin
      position_count    <= position_count_next;
      inside_range      <= inside_range_next;
      range_pointer     <= range_pointer_next;
      delimiter_pending <= delimiter_pending_next;
      delimiter_seen    <= delimiter_seen_next;
      first_field_count <= first_field_count_next;
      overflow_mark     <= overflow_mark_next;
    end
  end

endmodule

/* rtl/tcfs_drain.sv */
module tcfs_drain (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  tcfs_pkg::plan_t        plan,
  output tcfs_pkg::rd_t          rd,
  input  logic [7:0]             rd_data,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,
  output logic                   m_tlast,
  output logic                   m_tuser
);

  `include "text_column_field_selector_macros.svh"

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                       state;
  logic                       out_valid;
  logic [7:0]                 out_byte;
  logic                       out_last;
  logic                       out_flag;
  logic [tcfs_pkg::CNT_W-1:0] idx;
  logic [tcfs_pkg::CNT_W-1:0] fill;
  logic                       tail;
  logic [7:0]                 tail_byte;
  logic                       flag;
  logic                       rd_pend;
  logic                       rd_last;

  logic                       accept;
  logic                       slot_free;
  logic                       move;
  logic                       issue;
  logic                       done;
  logic                       start_drain;

  assign slot_free   = !out_valid || m_tready;
  assign s_tready    = (state == ST_IDLE) && slot_free;
  assign accept      = s_tvalid && s_tready;
  assign start_drain = plan.drain && (plan.count != '0);
  assign move        = (state == ST_DRAIN) && rd_pend && slot_free;
  assign issue       = (state == ST_DRAIN) && (idx != fill) && (!rd_pend || move);
  assign done        = (state == ST_DRAIN) && (idx == fill) && !rd_pend &&
                       (!tail || slot_free);

  assign rd.en   = issue;
  assign rd.addr = idx[tcfs_pkg::ADDR_W-1:0];

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;
  assign m_tuser  = out_flag;

  // Sequencer: walks the store, then sends the trailing byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      idx     <= '0;
      fill    <= '0;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && start_drain) begin
            state   <= ST_DRAIN;
            idx     <= '0;
            fill    <= plan.count;
            rd_pend <= 1'b0;
          end
        end
        ST_DRAIN: begin
          if (issue) begin
            idx     <= idx + 1'b1;
            rd_pend <= 1'b1;
          end else if (move) begin
            rd_pend <= 1'b0;
          end
          if (done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request details held for the length of a drain.
  always_ff @(posedge clk) begin
    if (accept) begin
      tail      <= plan.tail;
      tail_byte <= plan.tail_byte;
      flag      <= plan.flag;
    end
    if (issue) begin
      rd_last <= (idx == fill - 1'b1) && !tail;
    end
  end

  // Output register: one result waiting for the far side.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && !start_drain && plan.tail) || move || (done && tail)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !start_drain && plan.tail) begin
      out_byte <= plan.tail_byte;
      out_last <= 1'b1;
      out_flag <= plan.flag;
    end else if (move) begin
      out_byte <= rd_data;
      out_last <= rd_last;
      out_flag <= flag;
    end else if (done && tail) begin
      out_byte <= tail_byte;
      out_last <= 1'b1;
      out_flag <= flag;
    end
  end

  `TCFS_ASSERT_NOW(a_read_in_fill, issue, idx < fill)
  `TCFS_ASSERT_NOW(a_pend_in_drain, rd_pend, state == ST_DRAIN)
  `TCFS_ASSERT_NOW(a_partial_in_drain, out_valid && !out_last, state == ST_DRAIN)
  `TCFS_ASSERT_NEXT(a_drain_starts, accept && start_drain, state == ST_DRAIN)

endmodule

/* rtl/text_column_field_selector.sv */
// A single result is on the output in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output is taken and no field is buffered out.
// A byte that releases a buffered first field holds the input until the drain ends: the
// store's registered read port sends one buffered byte a cycle while the output is taken.
// Reset (rst, synchronous): registers to reset values, line state cleared; the
// first-field store keeps its contents and needs no clearing pass.
module text_column_field_selector (
  input  logic                             clk,
  input  logic                             rst,
  // Input text: [7:0] text_byte.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,
  // Results: [7:0] out_byte; tlast is last_of_run.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [7:0]                       m_tdata,
  output logic                             m_tlast,
  // [0] overflow_flag.
  output logic                             m_tuser,
  // Register writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tcfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tcfs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tcfs_pkg::plan_t plan;
  tcfs_pkg::wr_t   wr;
  tcfs_pkg::rd_t   rd;
  logic [7:0]      rd_data;
  logic            in_accept;

  assign in_accept = s_tvalid && s_tready;

  // Line state, registers and byte decoding.
  tcfs_line u_line (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .in_accept (in_accept),
    .in_byte   (s_tdata),
    .plan      (plan),
    .wr        (wr)
  );

  // First-field buffer.
  tcfs_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  // Result sequencing and output register.
  tcfs_drain u_drain (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .plan     (plan),
    .rd       (rd),
    .rd_data  (rd_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
